@@ rtl/core/fbp_pkg.sv @@
// Shared types and sizing constants for the RGB565 frame buffer port.
`default_nettype none

package fbp_pkg;

  // Visible frame geometry
  localparam int FRAME_WIDTH  = 480;
  localparam int FRAME_HEIGHT = 320;

  // Store size: the larger of the minimum window and the visible frame
  localparam longint MIN_BYTES   = 64'h4b000;
  localparam longint VIS_BYTES   = longint'(FRAME_WIDTH) * 2 * longint'(FRAME_HEIGHT);
  localparam longint FRAME_BYTES = (VIS_BYTES > MIN_BYTES) ? VIS_BYTES : MIN_BYTES;
  localparam int     STORE_WORDS = int'(FRAME_BYTES / 4);

  localparam int ADDR_BITS = $clog2(STORE_WORDS);
  localparam int PIX_BITS  = ADDR_BITS + 1;

  // Row / column widths of the stored pixel range
  localparam int COL_BITS     = $clog2(FRAME_WIDTH);
  localparam int ROW_BITS_RAW = $clog2(((2 * STORE_WORDS - 1) / FRAME_WIDTH) + 1);
  localparam int ROW_BITS     = (ROW_BITS_RAW > 0) ? ROW_BITS_RAW : 1;

  // Reciprocal for pixel index / FRAME_WIDTH, exact over PIX_BITS
  localparam int     DIV_SHIFT  = PIX_BITS + $clog2(FRAME_WIDTH);
  localparam longint DIV_RECIP  =
    ((longint'(1) << DIV_SHIFT) + longint'(FRAME_WIDTH) - 1) / longint'(FRAME_WIDTH);
  localparam int     RECIP_BITS = $clog2(DIV_RECIP + 1);
  localparam int     PROD_BITS  = PIX_BITS + RECIP_BITS;

  // Command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic        command;
    logic [31:0] address;
    logic [31:0] write_data;
  } fbp_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } fbp_rsp_t;

  // Second pipeline stage contents, handed to the result formatter
  typedef struct packed {
    logic                cmd;
    logic                hit;
    logic [PIX_BITS-1:0] pix;
    logic [ROW_BITS-1:0] row;
    logic [31:0]         data;
    logic [31:0]         rdata;
  } fbp_stage_t;

endpackage

`default_nettype wire

@@ rtl/core/fbp_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none

module fbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fbp_result.sv @@
// Result formatter: builds one result word from the second stage and pixel phase.
`default_nettype none

module fbp_result
  import fbp_pkg::*;
(
  input  wire fbp_stage_t s,
  input  wire logic       phase,
  output fbp_rsp_t        r
);

  logic [PIX_BITS-1:0] row_base;
  logic [COL_BITS-1:0] col0;
  logic [COL_BITS-1:0] col1;
  logic [ROW_BITS-1:0] row1;
  logic                wrap;
  logic [15:0]         colour;

  always_comb begin
    row_base = PIX_BITS'(s.row * FRAME_WIDTH);
    col0     = COL_BITS'(s.pix - row_base);
    wrap     = (col0 == COL_BITS'(FRAME_WIDTH - 1));
    col1     = wrap ? '0 : col0 + COL_BITS'(1);
    row1     = wrap ? s.row + ROW_BITS'(1) : s.row;
    colour   = phase ? s.data[15:0] : s.data[31:16];
  end

  always_comb begin
    r = '0;
    priority if (s.cmd == CMD_READ) begin
      r.kind      = KIND_READ;
      r.read_data = s.hit ? s.rdata : '0;
      r.last      = 1'b1;
    end else if (!s.hit) begin
      r.kind = KIND_REJECT;
      r.last = 1'b1;
    end else begin
      r.kind    = KIND_PIXEL;
      r.pixel_x = phase ? 9'(col1) : 9'(col0);
      r.pixel_y = phase ? 9'(row1) : 9'(s.row);
      r.red     = {colour[15:11], 3'b000};
      r.green   = {colour[10:5], 2'b00};
      r.blue    = {colour[4:0], 3'b000};
      r.last    = phase;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rgb565_framebuffer_port_unit.sv @@
// RGB565 frame buffer behind a 32-bit word port: top level.
// Path from accept to the first result word: stage 1, stage 2, output reg.
// Throughput: one read or rejected write per cycle while rsp_stall is low; an in-range write
//   sends its two pixel words through the single result register.
// Reset: control cleared at once, then a clearing pass zeroes all STORE_WORDS
//   (76800) store words, one per cycle, with req_stall held high throughout.
`default_nettype none

module rgb565_framebuffer_port_unit
  import fbp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire fbp_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output fbp_rsp_t      rsp
);

  // ---------------------------------------------------------------------
  // Store clearing pass after reset
  // ---------------------------------------------------------------------
  logic                 clr_busy;
  logic [ADDR_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_BITS'(1);
      if (clr_addr == ADDR_BITS'(STORE_WORDS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and pipeline flow
  // ---------------------------------------------------------------------
  logic       accept;
  logic       s1_valid;
  logic       s2_valid;
  logic       s2_phase;   // second pixel of a write pending
  logic       s2_load;
  logic       s2_retire;
  logic       out_load;
  fbp_rsp_t   res;

  assign out_load  = !rsp_valid || !rsp_stall;
  assign s2_retire = s2_valid && out_load && res.last;
  assign s2_load   = s1_valid && (!s2_valid || s2_retire);
  assign req_stall = clr_busy || (s1_valid && !s2_load);
  assign accept    = req_valid && !req_stall;

  // Word index and range check straight off the port
  logic [29:0]          req_word;
  logic                 req_inside;
  logic [ADDR_BITS-1:0] req_addr;

  assign req_word   = req.address[31:2];
  assign req_inside = (req_word < 30'(STORE_WORDS));
  assign req_addr   = req.address[ADDR_BITS+1:2];

  // ---------------------------------------------------------------------
  // Store: clear pass, or the single access of an accepted word
  // ---------------------------------------------------------------------
  logic                 ram_we;
  logic                 ram_re;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [31:0]          ram_wdata;
  logic [31:0]          ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = req_addr;
    ram_wdata = req.write_data;
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr;
      ram_wdata = '0;
    end else if (accept && req_inside) begin
      ram_we = (req.command == CMD_WRITE);
      ram_re = (req.command == CMD_READ);
    end
  end

  fbp_ram #(
    .WIDTH (32),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Stage 1: registered access; row = pixel index / FRAME_WIDTH by reciprocal
  // ---------------------------------------------------------------------
  logic                 s1_cmd;
  logic                 s1_inside;
  logic [PIX_BITS-1:0]  s1_pix;
  logic [31:0]          s1_data;
  logic [PROD_BITS-1:0] s1_prod;
  logic [PROD_BITS-1:0] s1_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd    <= req.command;
      s1_inside <= req_inside;
      s1_pix    <= {req_addr, 1'b0};   // first pixel of the word
      s1_data   <= req.write_data;
    end
  end

  assign s1_prod = PROD_BITS'(s1_pix) * PROD_BITS'(DIV_RECIP);
  assign s1_quot = s1_prod >> DIV_SHIFT;

  // ---------------------------------------------------------------------
  // Stage 2: holds the word until its last result has gone out
  // ---------------------------------------------------------------------
  fbp_stage_t s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_phase <= 1'b0;
    end else begin
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (s2_retire) begin
        s2_valid <= 1'b0;
      end
      if (s2_retire || s2_load) begin
        s2_phase <= 1'b0;
      end else if (s2_valid && out_load) begin
        s2_phase <= 1'b1;
      end
    end
  end

  // Store read data is captured here; the store is idle while stage 1 waits
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2.cmd   <= s1_cmd;
      s2.hit   <= s1_inside;
      s2.pix   <= s1_pix;
      s2.row   <= ROW_BITS'(s1_quot);
      s2.data  <= s1_data;
      s2.rdata <= ram_rdata;
    end
  end

  fbp_result u_result (
    .s     (s2),
    .phase (s2_phase),
    .r     (res)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s2_valid) begin
      rsp <= res;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // Second-pixel phase only ever belongs to an in-range write
  assert property (@(posedge clk) disable iff (rst)
    s2_phase |-> (s2_valid && s2.cmd == CMD_WRITE && s2.hit))
    else $error("pixel phase set outside an in-range write");

  // A taken first pixel is followed at once by its closing pixel
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && rsp.kind == KIND_PIXEL && !rsp.last)
      |=> (rsp_valid && rsp.kind == KIND_PIXEL && rsp.last))
    else $error("second pixel word missing after the first");

  // Reads and rejects are single-word results
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind != KIND_PIXEL) |-> rsp.last)
    else $error("read or reject word without last");

  // Nothing enters while the store is being cleared
  assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s1_valid && !s2_valid && !rsp_valid)
    else $error("pipeline busy during clearing pass");

endmodule

`default_nettype wire
